// ===== rtl/affine_rotozoom_pixel_fetch_assert.svh =====
// Assertion macros for the affine rotate/zoom pixel fetch block.
// Used by the controller; expects clk and rst in scope.
`ifndef AFFINE_ROTOZOOM_PIXEL_FETCH_ASSERT_SVH
`define AFFINE_ROTOZOOM_PIXEL_FETCH_ASSERT_SVH

`ifndef SYNTHESIS
`define ARPF_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define ARPF_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ARPF_ASSERT(label, prop, msg)
`define ARPF_ASSERT_RST(label, prop, msg)
`endif

`endif

// ===== rtl/arpf_pkg.sv =====
// Shared constants, codes and types of the affine rotate/zoom pixel fetch.
// No dependencies.
package arpf_pkg;

  localparam int SRC_W_LOG2  = 8;
  localparam int SRC_H_LOG2  = 8;
  localparam int SCREEN_BITS = 12;

  localparam int FRAC_BITS   = 16;
  localparam int FIX_W       = 32;
  localparam int ADDR_W      = 16;
  localparam int STORE_DEPTH = 1 << ADDR_W;
  localparam int PIX_W       = 16;
  localparam int CODE_W      = 8;
  localparam int ENTRY_W     = PIX_W + CODE_W;
  localparam int COORD_W     = 12;
  localparam int COLOR_W     = 17;
  localparam int KIND_W      = 2;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 32;

  localparam int SCR_EFF = (SCREEN_BITS < COORD_W) ? SCREEN_BITS : COORD_W;
  localparam logic [COORD_W-1:0] SCR_MASK = COORD_W'((64'd1 << SCR_EFF) - 64'd1);

  localparam logic [FIX_W-1:0] INC_ONE = 32'h0001_0000;

  localparam logic [KIND_W-1:0] KIND_LOAD   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_ORIGIN = 2'd1;
  localparam logic [KIND_W-1:0] KIND_FETCH  = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_INC_XX      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INC_XY      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_INC_YX      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_INC_YY      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_WRAP_ENABLE = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_PAL_OFFSET  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_TRANS_MASK  = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_TRANS_MATCH = 3'd7;

  typedef struct packed {
    logic load_entry;
    logic load_origin;
    logic capture;
    logic issue_read;
    logic load_out;
  } ctl_cmd_t;

endpackage

// ===== rtl/arpf_if.sv =====
// Request, result and register write channels of the pixel fetch block.
// Depends on arpf_pkg.
interface arpf_req_if import arpf_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [KIND_W-1:0]    kind;
  logic [ADDR_W-1:0]    src_index;
  logic [PIX_W-1:0]     src_pixel;
  logic [CODE_W-1:0]    src_code;
  logic [FIX_W-1:0]     origin_x;
  logic [FIX_W-1:0]     origin_y;
  logic [COORD_W-1:0]   screen_x;
  logic [COORD_W-1:0]   screen_y;

  modport source (output valid, kind, src_index, src_pixel, src_code, origin_x, origin_y,
                  screen_x, screen_y, input ready);
  modport sink (input valid, kind, src_index, src_pixel, src_code, origin_x, origin_y,
                screen_x, screen_y, output ready);
endinterface

interface arpf_res_if import arpf_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               plot;
  logic [COLOR_W-1:0] color_index;
  logic [COORD_W-1:0] out_x;
  logic [COORD_W-1:0] out_y;

  modport source (output valid, plot, color_index, out_x, out_y, input ready);
  modport sink (input valid, plot, color_index, out_x, out_y, output ready);
endinterface

interface arpf_cfg_if import arpf_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/arpf_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module arpf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/arpf_ctrl.sv =====
// Sequencer of the pixel fetch: request handshake, fetch steps, result valid.
// Depends on arpf_pkg and affine_rotozoom_pixel_fetch_assert.svh.
`include "affine_rotozoom_pixel_fetch_assert.svh"

module arpf_ctrl import arpf_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic [KIND_W-1:0] in_kind,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output ctl_cmd_t          cmd
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MUL  = 3'd1;
  localparam logic [2:0] S_SUM  = 3'd2;
  localparam logic [2:0] S_POS  = 3'd3;
  localparam logic [2:0] S_ADDR = 3'd4;
  localparam logic [2:0] S_DATA = 3'd5;

  logic [2:0] state;
  logic [2:0] state_next;
  logic       out_valid_next;
  logic       accept;
  logic       out_free;

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;

  always_comb begin
    cmd.load_entry  = accept && (in_kind == KIND_LOAD);
    cmd.load_origin = accept && (in_kind == KIND_ORIGIN);
    cmd.capture     = accept && (in_kind == KIND_FETCH);
    cmd.issue_read  = (state == S_ADDR);
    cmd.load_out    = (state == S_DATA) && out_free;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (cmd.capture) begin
          state_next = S_MUL;
        end
      end
      S_MUL:  state_next = S_SUM;
      S_SUM:  state_next = S_POS;
      S_POS:  state_next = S_ADDR;
      S_ADDR: state_next = S_DATA;
      S_DATA: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_next = out_valid;
    if (cmd.load_out) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  `ARPF_ASSERT(a_fetch_starts, cmd.capture |=> state == S_MUL, "fetch did not start")
  `ARPF_ASSERT(a_result_held, state == S_DATA && out_valid && !out_ready |=> state == S_DATA, "result dropped while output busy")
  `ARPF_ASSERT(a_result_source, $rose(out_valid) |-> $past(state) == S_DATA, "result raised outside data step")
  `ARPF_ASSERT_RST(a_reset_idle, rst |=> state == S_IDLE && !out_valid, "reset did not clear control")

endmodule

// ===== rtl/arpf_dpath.sv =====
// Datapath of the pixel fetch: registers, source point arithmetic, source store,
// transparency test and result register. Depends on arpf_pkg and arpf_ram.
module arpf_dpath import arpf_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  ctl_cmd_t              cmd,
  input  logic                  cfg_valid,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic [ADDR_W-1:0]     src_index,
  input  logic [PIX_W-1:0]      src_pixel,
  input  logic [CODE_W-1:0]     src_code,
  input  logic [FIX_W-1:0]      origin_x,
  input  logic [FIX_W-1:0]      origin_y,
  input  logic [COORD_W-1:0]    screen_x,
  input  logic [COORD_W-1:0]    screen_y,
  output logic                  plot,
  output logic [COLOR_W-1:0]    color_index,
  output logic [COORD_W-1:0]    out_x,
  output logic [COORD_W-1:0]    out_y
);

  logic [FIX_W-1:0]   inc_xx;
  logic [FIX_W-1:0]   inc_xy;
  logic [FIX_W-1:0]   inc_yx;
  logic [FIX_W-1:0]   inc_yy;
  logic               wrap_enable;
  logic [PIX_W-1:0]   pal_base;
  logic [CODE_W-1:0]  trans_mask;
  logic [CODE_W-1:0]  trans_match;
  logic [FIX_W-1:0]   start_x_reg;
  logic [FIX_W-1:0]   start_y_reg;

  logic [COORD_W-1:0] x_reg;
  logic [COORD_W-1:0] y_reg;
  logic [FIX_W-1:0]   x_ext;
  logic [FIX_W-1:0]   y_ext;
  logic [FIX_W-1:0]   prod_xx;
  logic [FIX_W-1:0]   prod_xy;
  logic [FIX_W-1:0]   prod_yx;
  logic [FIX_W-1:0]   prod_yy;
  logic [FIX_W-1:0]   sum_x;
  logic [FIX_W-1:0]   sum_y;
  logic [FIX_W-1:0]   pos_x;
  logic [FIX_W-1:0]   pos_y;

  logic [SRC_W_LOG2-1:0]            col;
  logic [SRC_H_LOG2-1:0]            row;
  logic [SRC_W_LOG2+SRC_H_LOG2-1:0] row_col;
  logic [ADDR_W-1:0]                rd_addr;
  logic                             in_src;
  logic                             in_src_reg;
  logic [ENTRY_W-1:0]               rd_entry;
  logic [CODE_W-1:0]                rd_code;
  logic [COLOR_W-1:0]               color_sum;
  logic                             hit;

  always_ff @(posedge clk) begin
    if (rst) begin
      inc_xx      <= INC_ONE;
      inc_xy      <= '0;
      inc_yx      <= '0;
      inc_yy      <= INC_ONE;
      wrap_enable <= 1'b0;
      pal_base    <= '0;
      trans_mask  <= '0;
      trans_match <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_INC_XX:      inc_xx      <= cfg_data;
        REG_INC_XY:      inc_xy      <= cfg_data;
        REG_INC_YX:      inc_yx      <= cfg_data;
        REG_INC_YY:      inc_yy      <= cfg_data;
        REG_WRAP_ENABLE: wrap_enable <= cfg_data[0];
        REG_PAL_OFFSET:  pal_base    <= cfg_data[PIX_W-1:0];
        REG_TRANS_MASK:  trans_mask  <= cfg_data[CODE_W-1:0];
        REG_TRANS_MATCH: trans_match <= cfg_data[CODE_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      start_x_reg <= '0;
      start_y_reg <= '0;
    end else if (cmd.load_origin) begin
      start_x_reg <= origin_x;
      start_y_reg <= origin_y;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      x_reg <= screen_x & SCR_MASK;
      y_reg <= screen_y & SCR_MASK;
    end
  end

  assign x_ext = FIX_W'(x_reg);
  assign y_ext = FIX_W'(y_reg);

  // Products keep their low 32 bits: the source point is taken modulo 2^32.
  always_ff @(posedge clk) begin
    prod_xx <= x_ext * inc_xx;
    prod_xy <= x_ext * inc_xy;
    prod_yx <= y_ext * inc_yx;
    prod_yy <= y_ext * inc_yy;
    sum_x   <= prod_xx + prod_yx;
    sum_y   <= prod_xy + prod_yy;
    pos_x   <= start_x_reg + sum_x;
    pos_y   <= start_y_reg + sum_y;
  end

  // Clip mode keeps a point only when no integer bit above the source size is set.
  assign col     = pos_x[FRAC_BITS +: SRC_W_LOG2];
  assign row     = pos_y[FRAC_BITS +: SRC_H_LOG2];
  assign row_col = {row, col};
  assign rd_addr = ADDR_W'(row_col);
  assign in_src  = wrap_enable ||
                   ((pos_x[FIX_W-1:FRAC_BITS+SRC_W_LOG2] == '0) &&
                    (pos_y[FIX_W-1:FRAC_BITS+SRC_H_LOG2] == '0));

  always_ff @(posedge clk) begin
    if (cmd.issue_read) begin
      in_src_reg <= in_src;
    end
  end

  arpf_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(STORE_DEPTH)
  ) u_store (
    .clk  (clk),
    .we   (cmd.load_entry),
    .waddr(src_index),
    .wdata({src_code, src_pixel}),
    .re   (cmd.issue_read),
    .raddr(rd_addr),
    .rdata(rd_entry)
  );

  assign rd_code   = rd_entry[ENTRY_W-1:PIX_W];
  assign color_sum = {1'b0, rd_entry[PIX_W-1:0]} + {1'b0, pal_base};
  assign hit       = in_src_reg && ((rd_code & trans_mask) == trans_match);

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      plot        <= hit;
      color_index <= hit ? color_sum : '0;
      out_x       <= x_reg;
      out_y       <= y_reg;
    end
  end

endmodule

// ===== rtl/affine_rotozoom_pixel_fetch.sv =====
// Affine rotate/zoom pixel fetch: load, origin and fetch requests in, pixel results out.
// A load, origin or unused-kind request is taken in idle and leaves the block idle. A fetch
// request keeps the request side busy through its steps: the accepting cycle, multiply, two
// adds, address and store read, then result load, where its result is registered. One fetch is
// in flight at a time through the store's single read port. The result register lets the next
// request in while a result waits to be taken; a following fetch then waits in its last step
// until the result is taken. The 65536-entry source store is not cleared; reading an entry
// never loaded gives undefined pixel data. Register writes are taken every cycle and apply at
// once, so they belong only where no fetch is in flight.
// Depends on arpf_pkg, arpf_if, arpf_ctrl and arpf_dpath.
module affine_rotozoom_pixel_fetch import arpf_pkg::*; (
  input logic      clk,
  input logic      rst,
  arpf_cfg_if.sink cfg,
  arpf_req_if.sink req,
  arpf_res_if.source res
);

  ctl_cmd_t cmd;
  logic     ctl_in_ready;
  logic     ctl_out_valid;

  assign cfg.ready = 1'b1;
  assign req.ready = ctl_in_ready;
  assign res.valid = ctl_out_valid;

  arpf_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .in_kind  (req.kind),
    .in_ready (ctl_in_ready),
    .out_valid(ctl_out_valid),
    .out_ready(res.ready),
    .cmd      (cmd)
  );

  arpf_dpath u_dpath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .cfg_valid  (cfg.valid),
    .cfg_index  (cfg.index),
    .cfg_data   (cfg.data),
    .src_index  (req.src_index),
    .src_pixel  (req.src_pixel),
    .src_code   (req.src_code),
    .origin_x   (req.origin_x),
    .origin_y   (req.origin_y),
    .screen_x   (req.screen_x),
    .screen_y   (req.screen_y),
    .plot       (res.plot),
    .color_index(res.color_index),
    .out_x      (res.out_x),
    .out_y      (res.out_y)
  );

endmodule

// ===== tb/affine_rotozoom_pixel_fetch_tb.sv =====
// Self-checking testbench for affine_rotozoom_pixel_fetch: load, origin and fetch requests
// with random flow control, a built-in pixel predictor and an in-order result check.
// Depends on arpf_pkg, the arpf_*_if interfaces and the block's RTL.
module affine_rotozoom_pixel_fetch_tb;
  import arpf_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
  localparam int DRAIN_CYCLES = 12;
  localparam int HOLD_CYCLES  = 300;
  localparam int RAND_ITEMS   = 700;
  localparam int MAX_REPORTS  = 30;

  typedef struct {
    logic [KIND_W-1:0]  kind;
    logic [ADDR_W-1:0]  src_index;
    logic [PIX_W-1:0]   src_pixel;
    logic [CODE_W-1:0]  src_code;
    logic [FIX_W-1:0]   origin_x;
    logic [FIX_W-1:0]   origin_y;
    logic [COORD_W-1:0] screen_x;
    logic [COORD_W-1:0] screen_y;
  } fetch_req_t;

  typedef struct {
    logic               plot;
    logic [COLOR_W-1:0] color;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
  } pix_result_t;

  typedef struct {
    logic [FIX_W-1:0]  inc_xx;
    logic [FIX_W-1:0]  inc_xy;
    logic [FIX_W-1:0]  inc_yx;
    logic [FIX_W-1:0]  inc_yy;
    logic              wrap;
    logic [PIX_W-1:0]  pal;
    logic [CODE_W-1:0] tmask;
    logic [CODE_W-1:0] tmatch;
  } rz_cfg_t;

  localparam rz_cfg_t CFG_AT_RESET = '{INC_ONE, '0, '0, INC_ONE, 1'b0, '0, '0, '0};

  logic clk = 1'b0;
  logic rst = 1'b1;

  arpf_cfg_if cfg_bus ();
  arpf_req_if req_bus ();
  arpf_res_if res_bus ();

  affine_rotozoom_pixel_fetch i_dut (
    .clk (clk),
    .rst (rst),
    .cfg (cfg_bus),
    .req (req_bus),
    .res (res_bus)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  fetch_req_t  pending_reqs[$];
  pix_result_t pixel_results_due[$];

  // predictor state
  logic [ENTRY_W-1:0] src_mem [STORE_DEPTH];
  rz_cfg_t            pred_cfg = CFG_AT_RESET;
  logic [FIX_W-1:0]   pred_ox = '0;
  logic [FIX_W-1:0]   pred_oy = '0;

  // stimulus-side shadow, used to keep every store read that is not clipped on a loaded entry
  bit                 loaded [STORE_DEPTH];
  rz_cfg_t            gen_cfg = CFG_AT_RESET;
  logic [FIX_W-1:0]   gen_ox = '0;
  logic [FIX_W-1:0]   gen_oy = '0;
  int                 items_total = 0;

  int errors = 0;
  int loads_seen = 0, origins_seen = 0, fetches_seen = 0, ignored_seen = 0;
  int results_seen = 0, plotted = 0, rejected = 0, transparent = 0, settings_used = 0;

  int burst_left, gap_left;
  int ready_cyc, ready_mode;
  logic hold_off = 1'b0;
  bit   random_started = 1'b0;

  // Maps a screen pixel to a source store address; returns 0 when clipped.
  function automatic bit map_source_point(input rz_cfg_t c, input logic [FIX_W-1:0] ox,
                                          input logic [FIX_W-1:0] oy,
                                          input logic [COORD_W-1:0] sx,
                                          input logic [COORD_W-1:0] sy,
                                          output logic [ADDR_W-1:0] addr);
    logic [FIX_W-1:0] xs, ys, px, py, col, row;
    xs = {20'd0, sx & SCR_MASK};
    ys = {20'd0, sy & SCR_MASK};
    px = ox + xs * c.inc_xx + ys * c.inc_yx;
    py = oy + xs * c.inc_xy + ys * c.inc_yy;
    addr = '0;
    if (c.wrap) begin
      col = (px >> FRAC_BITS) & ((32'd1 << SRC_W_LOG2) - 32'd1);
      row = (py >> FRAC_BITS) & ((32'd1 << SRC_H_LOG2) - 32'd1);
    end else begin
      if ({32'd0, px} >= (64'd1 << (SRC_W_LOG2 + FRAC_BITS)) ||
          {32'd0, py} >= (64'd1 << (SRC_H_LOG2 + FRAC_BITS)))
        return 1'b0;
      col = px >> FRAC_BITS;
      row = py >> FRAC_BITS;
    end
    addr = ADDR_W'((row << SRC_W_LOG2) | col);
    return 1'b1;
  endfunction

  function automatic void apply_reg_write(input logic [CFG_IDX_W-1:0] idx,
                                          input logic [CFG_DATA_W-1:0] val);
    case (idx)
      REG_INC_XX:      pred_cfg.inc_xx = val;
      REG_INC_XY:      pred_cfg.inc_xy = val;
      REG_INC_YX:      pred_cfg.inc_yx = val;
      REG_INC_YY:      pred_cfg.inc_yy = val;
      REG_WRAP_ENABLE: pred_cfg.wrap   = val[0];
      REG_PAL_OFFSET:  pred_cfg.pal    = val[PIX_W-1:0];
      REG_TRANS_MASK:  pred_cfg.tmask  = val[CODE_W-1:0];
      REG_TRANS_MATCH: pred_cfg.tmatch = val[CODE_W-1:0];
      default: ;
    endcase
  endfunction

  function automatic void predict_request(input fetch_req_t r);
    logic [ADDR_W-1:0]  a;
    logic [ENTRY_W-1:0] ent;
    pix_result_t        want;
    case (r.kind)
      KIND_LOAD: begin
        src_mem[r.src_index] = {r.src_code, r.src_pixel};
        loads_seen++;
      end
      KIND_ORIGIN: begin
        pred_ox = r.origin_x;
        pred_oy = r.origin_y;
        origins_seen++;
      end
      KIND_FETCH: begin
        want.plot  = 1'b0;
        want.color = '0;
        want.x     = r.screen_x & SCR_MASK;
        want.y     = r.screen_y & SCR_MASK;
        if (map_source_point(pred_cfg, pred_ox, pred_oy, r.screen_x, r.screen_y, a)) begin
          ent = src_mem[a];
          if ((ent[ENTRY_W-1:PIX_W] & pred_cfg.tmask) == pred_cfg.tmatch) begin
            want.plot  = 1'b1;
            want.color = {1'b0, ent[PIX_W-1:0]} + {1'b0, pred_cfg.pal};
            plotted++;
          end else begin
            transparent++;
          end
        end else begin
          rejected++;
        end
        pixel_results_due.push_back(want);
        fetches_seen++;
      end
      default: ignored_seen++;
    endcase
  endfunction

  function automatic void compare_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
    if (want !== got) begin
      errors++;
      if (errors <= MAX_REPORTS)
        $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
    end
  endfunction

  function automatic void check_result(input pix_result_t got);
    pix_result_t want;
    if (pixel_results_due.size() == 0) begin
      errors++;
      if (errors <= MAX_REPORTS)
        $display(
          "%0t ns: result with none pending, expected nothing, actual plot=%0d color=%0h x=%0d y=%0d",
          $time, got.plot, got.color, got.x, got.y);
      return;
    end
    want = pixel_results_due.pop_front();
    results_seen++;
    compare_field("plot", 32'(want.plot), 32'(got.plot));
    compare_field("color_index", 32'(want.color), 32'(got.color));
    compare_field("out_x", 32'(want.x), 32'(got.x));
    compare_field("out_y", 32'(want.y), 32'(got.y));
  endfunction

  // request driver: bursts of random length separated by random gaps
  always @(posedge clk) begin
    if (rst) begin
      req_bus.valid <= 1'b0;
      burst_left    <= 8;
      gap_left      <= 0;
    end else if (!req_bus.valid || req_bus.ready) begin
      if (req_bus.valid) pending_reqs.delete(0);
      if (gap_left != 0 || pending_reqs.size() == 0) begin
        req_bus.valid <= 1'b0;
        if (gap_left != 0) gap_left <= gap_left - 1;
      end else begin
        req_bus.valid     <= 1'b1;
        req_bus.kind      <= pending_reqs[0].kind;
        req_bus.src_index <= pending_reqs[0].src_index;
        req_bus.src_pixel <= pending_reqs[0].src_pixel;
        req_bus.src_code  <= pending_reqs[0].src_code;
        req_bus.origin_x  <= pending_reqs[0].origin_x;
        req_bus.origin_y  <= pending_reqs[0].origin_y;
        req_bus.screen_x  <= pending_reqs[0].screen_x;
        req_bus.screen_y  <= pending_reqs[0].screen_y;
        if (burst_left > 1) begin
          burst_left <= burst_left - 1;
        end else begin
          burst_left <= $urandom_range(1, 24);
          gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
        end
      end
    end
  end

  // result stall pattern; the mode is drawn again at random as the cycle counter runs
  always @(posedge clk) begin : res_stall
    logic take;
    if (rst) begin
      res_bus.ready <= 1'b0;
      ready_cyc     <= 0;
      ready_mode    <= 0;
    end else begin
      ready_cyc <= ready_cyc + 1;
      if (ready_cyc % 97 == 0) ready_mode <= $urandom_range(0, 3);
      case (ready_mode)
        0:       take = 1'b1;
        1:       take = 1'($urandom_range(0, 1));
        2:       take = (ready_cyc % 5) < 3;
        default: take = ($urandom_range(0, 3) == 0);
      endcase
      res_bus.ready <= take && !hold_off;
    end
  end

  // long result hold-off so the block backs up onto the request side
  initial begin
    wait (random_started);
    repeat (40) @(posedge clk);
    hold_off <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_off <= 1'b0;
  end

  always @(posedge clk) begin : monitor
    fetch_req_t  r;
    pix_result_t got;
    if (!rst) begin
      if (cfg_bus.valid && cfg_bus.ready) apply_reg_write(cfg_bus.index, cfg_bus.data);
      if (res_bus.valid && res_bus.ready) begin
        got.plot  = res_bus.plot;
        got.color = res_bus.color_index;
        got.x     = res_bus.out_x;
        got.y     = res_bus.out_y;
        check_result(got);
      end
      if (req_bus.valid && req_bus.ready) begin
        r.kind      = req_bus.kind;
        r.src_index = req_bus.src_index;
        r.src_pixel = req_bus.src_pixel;
        r.src_code  = req_bus.src_code;
        r.origin_x  = req_bus.origin_x;
        r.origin_y  = req_bus.origin_y;
        r.screen_x  = req_bus.screen_x;
        r.screen_y  = req_bus.screen_y;
        predict_request(r);
      end
    end
  end

  function automatic fetch_req_t rand_req(input logic [KIND_W-1:0] k);
    fetch_req_t r;
    r.kind      = k;
    r.src_index = ADDR_W'($urandom);
    r.src_pixel = PIX_W'($urandom);
    r.src_code  = CODE_W'($urandom);
    r.origin_x  = $urandom;
    r.origin_y  = $urandom;
    r.screen_x  = COORD_W'($urandom);
    r.screen_y  = COORD_W'($urandom);
    return r;
  endfunction

  function automatic void push_req(input fetch_req_t r);
    pending_reqs.push_back(r);
    if (r.kind != KIND_UNUSED) items_total++;
  endfunction

  function automatic logic [CODE_W-1:0] load_code();
    if ($urandom_range(0, 1))
      return (gen_cfg.tmatch & gen_cfg.tmask) | (CODE_W'($urandom) & ~gen_cfg.tmask);
    return CODE_W'($urandom);
  endfunction

  function automatic void add_load(input logic [ADDR_W-1:0] idx, input logic [PIX_W-1:0] pix,
                                   input logic [CODE_W-1:0] code);
    fetch_req_t r;
    r = rand_req(KIND_LOAD);
    r.src_index = idx;
    r.src_pixel = pix;
    r.src_code  = code;
    loaded[idx] = 1'b1;
    push_req(r);
  endfunction

  function automatic void add_origin(input logic [FIX_W-1:0] ox, input logic [FIX_W-1:0] oy);
    fetch_req_t r;
    r = rand_req(KIND_ORIGIN);
    r.origin_x = ox;
    r.origin_y = oy;
    gen_ox = ox;
    gen_oy = oy;
    push_req(r);
  endfunction

  // loads the addressed entry first if it was never written
  function automatic void add_fetch(input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y);
    fetch_req_t        r;
    logic [ADDR_W-1:0] a;
    if (map_source_point(gen_cfg, gen_ox, gen_oy, x, y, a) && !loaded[a])
      add_load(a, PIX_W'($urandom), load_code());
    r = rand_req(KIND_FETCH);
    r.screen_x = x;
    r.screen_y = y;
    push_req(r);
  endfunction

  function automatic logic [FIX_W-1:0] rand_inc(input bit gentle);
    if (gentle) return 32'($urandom_range(0, 32'h60000)) - 32'h30000;
    case ($urandom_range(0, 7))
      0:       return INC_ONE;
      1:       return 32'hFFFF_0000;
      2:       return '0;
      3:       return 32'($urandom_range(0, 32'h1000)) - 32'h800;
      4:       return $urandom;
      5:       return 32'h8000_0000;
      6:       return 32'h7FFF_FFFF;
      default: return 32'($urandom_range(0, 32'h60000)) - 32'h30000;
    endcase
  endfunction

  function automatic logic [FIX_W-1:0] rand_origin();
    if ($urandom_range(0, 3) != 0) return $urandom_range(0, 32'h00FF_FFFF);
    return $urandom;
  endfunction

  function automatic rz_cfg_t rand_cfg();
    rz_cfg_t c;
    bit      gentle;
    gentle   = ($urandom_range(0, 4) < 3);
    c.inc_xx = rand_inc(gentle);
    c.inc_xy = rand_inc(gentle);
    c.inc_yx = rand_inc(gentle);
    c.inc_yy = rand_inc(gentle);
    c.wrap   = 1'($urandom_range(0, 1));
    case ($urandom_range(0, 2))
      0:       c.pal = '0;
      1:       c.pal = 16'hFFFF;
      default: c.pal = PIX_W'($urandom);
    endcase
    case ($urandom_range(0, 3))
      0: begin
        c.tmask  = '0;
        c.tmatch = '0;
      end
      1: begin
        c.tmask  = 8'hFF;
        c.tmatch = CODE_W'($urandom);
      end
      2: begin
        c.tmask  = CODE_W'($urandom);
        c.tmatch = CODE_W'($urandom) & c.tmask;
      end
      default: begin
        // match bit outside the mask: nothing plots
        c.tmask  = CODE_W'($urandom) & 8'h7F;
        c.tmatch = CODE_W'($urandom) | 8'h80;
      end
    endcase
    return c;
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= val;
    do @(posedge clk); while (!cfg_bus.ready);
    cfg_bus.valid <= 1'b0;
  endtask

  task automatic set_regs(input rz_cfg_t c);
    gen_cfg = c;
    write_reg(REG_INC_XX, c.inc_xx);
    write_reg(REG_INC_XY, c.inc_xy);
    write_reg(REG_INC_YX, c.inc_yx);
    write_reg(REG_INC_YY, c.inc_yy);
    write_reg(REG_WRAP_ENABLE, (32'($urandom) & ~32'd1) | {31'd0, c.wrap});
    write_reg(REG_PAL_OFFSET, {16'($urandom), c.pal});
    write_reg(REG_TRANS_MASK, {24'($urandom), c.tmask});
    write_reg(REG_TRANS_MATCH, {24'($urandom), c.tmatch});
    settings_used++;
    @(negedge clk);
  endtask

  task automatic wait_idle();
    do @(posedge clk);
    while (pending_reqs.size() != 0 || req_bus.valid || pixel_results_due.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  initial begin : stimulus
    rz_cfg_t          c;
    fetch_req_t       r;
    int               rand_target, phase_goal, lines, n;
    logic [COORD_W-1:0] x0, y0;
    req_bus.valid     = 1'b0;
    req_bus.kind      = KIND_LOAD;
    req_bus.src_index = '0;
    req_bus.src_pixel = '0;
    req_bus.src_code  = '0;
    req_bus.origin_x  = '0;
    req_bus.origin_y  = '0;
    req_bus.screen_x  = '0;
    req_bus.screen_y  = '0;
    res_bus.ready     = 1'b0;
    cfg_bus.valid     = 1'b0;
    cfg_bus.index     = REG_INC_XX;
    cfg_bus.data      = '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);
    settings_used = 1;

    // directed: corners, clip edges, negative origin, ignored kind
    add_load(16'h0000, 16'hFFFF, 8'h00);
    add_load(16'hFFFF, 16'h0000, 8'hFF);
    add_load(16'h00FF, PIX_W'($urandom), CODE_W'($urandom));
    add_load(16'hFF00, PIX_W'($urandom), CODE_W'($urandom));
    add_origin('0, '0);
    add_fetch(12'd0, 12'd0);
    add_fetch(12'd255, 12'd255);
    add_fetch(12'd255, 12'd0);
    add_fetch(12'd0, 12'd255);
    add_fetch(12'd256, 12'd0);
    add_fetch(12'd0, 12'd256);
    add_fetch(12'hFFF, 12'hFFF);
    r = '{KIND_UNUSED, '1, '1, '1, '1, '1, '1, '1};
    push_req(r);
    add_origin(32'hFFFF_0000, 32'hFFFF_8000);
    add_fetch(12'd0, 12'd0);
    add_fetch(12'd1, 12'd1);
    add_origin(32'h00FF_FFFF, 32'h00FF_FFFF);
    add_fetch(12'd0, 12'd0);
    add_fetch(12'd1, 12'd0);
    wait_idle();

    c = CFG_AT_RESET;
    c.wrap   = 1'b1;
    c.pal    = 16'hFFFF;
    c.tmask  = 8'hFF;
    c.tmatch = 8'hFF;
    set_regs(c);
    add_origin('0, '0);
    add_load(16'h0101, 16'hFFFF, 8'hFF);
    add_fetch(12'hFFF, 12'hFFF);
    add_fetch(12'd257, 12'd1);
    add_fetch(12'd0, 12'd0);
    wait_idle();

    c.wrap   = 1'b0;
    c.tmask  = 8'h0F;
    c.tmatch = 8'h10;
    set_regs(c);
    add_fetch(12'd255, 12'd255);
    wait_idle();

    random_started = 1'b1;
    rand_target = items_total + RAND_ITEMS;
    for (int phase = 0; items_total < rand_target; phase++) begin
      if (phase == 0) begin
        c = '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
              1'b1, 16'hFFFF, 8'hFF, 8'h00};
      end else if (phase == 1) begin
        c = '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
              1'b0, 16'h0000, 8'h00, 8'h00};
      end else begin
        c = rand_cfg();
      end
      set_regs(c);
      phase_goal = items_total + $urandom_range(70, 110);
      while (items_total < phase_goal) begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3, 4, 5: begin
            add_origin(rand_origin(), rand_origin());
            lines = $urandom_range(1, 3);
            repeat (lines) begin
              y0 = ($urandom_range(0, 7) == 0) ? COORD_W'($urandom) :
                                                 COORD_W'($urandom_range(0, 63));
              x0 = ($urandom_range(0, 7) == 0) ? COORD_W'($urandom) :
                                                 COORD_W'($urandom_range(0, 200));
              n  = $urandom_range(3, 12);
              for (int i = 0; i < n; i++) add_fetch(COORD_W'(x0 + i), y0);
            end
          end
          6: add_load(ADDR_W'($urandom), PIX_W'($urandom), load_code());
          7: add_fetch(COORD_W'($urandom), COORD_W'($urandom));
          8: begin
            add_origin($urandom, $urandom);
            add_fetch(COORD_W'($urandom), COORD_W'($urandom));
            add_fetch(COORD_W'($urandom_range(0, 15)), COORD_W'($urandom_range(0, 15)));
          end
          default: push_req(rand_req(KIND_UNUSED));
        endcase
      end
      wait_idle();
    end

    $display("Covered %0d loads, %0d origins, %0d fetches, %0d ignored, %0d register sets",
             loads_seen, origins_seen, fetches_seen, ignored_seen, settings_used);
    $display("Checked %0d results: %0d plotted, %0d outside the source, %0d transparent",
             results_seen, plotted, rejected, transparent);
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin : watchdog
    #1_000_000;
    $display("Timeout with %0d requests queued and %0d results outstanding",
             pending_reqs.size(), pixel_results_due.size());
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
